[rtl/chained_hash_table_core_defines.svh]
// Assertion macros used by the hash table back end
`ifndef CHAINED_HASH_TABLE_CORE_DEFINES_SVH
`define CHAINED_HASH_TABLE_CORE_DEFINES_SVH

// Same-cycle implication, checked on every rising clock outside reset
`define CHT_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("hash table check failed");

// Next-cycle implication, checked on every rising clock outside reset
`define CHT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("hash table check failed");

`endif

[rtl/cht_pkg.sv]
`default_nettype none
package cht_pkg;

    // default sizes of the table
    localparam int NUM_BINS_DEF    = 64;
    localparam int MAX_ENTRIES_DEF = 256;

    // field widths
    localparam int CMD_W    = 2;
    localparam int STATUS_W = 2;
    localparam int KEY_W    = 32;
    localparam int DATA_W   = 32;

    // command codes
    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd1;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;

    // status codes
    localparam logic [STATUS_W-1:0] STAT_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_MISS = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_FULL = 2'd2;

    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [KEY_W-1:0]  key;
        logic [DATA_W-1:0] data_in;
    } t_in;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [DATA_W-1:0]   data_out;
    } t_out;

endpackage
`default_nettype wire

[rtl/cht_front.sv]
`default_nettype none
module cht_front #(
    parameter int NUM_BINS = cht_pkg::NUM_BINS_DEF,
    parameter int BIN_W    = $clog2(NUM_BINS)
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_enable,
    input  wire logic             i_valid,
    output logic                  o_ready,
    input  wire cht_pkg::t_in     i_item,
    output logic                  o_valid,
    input  wire logic             i_ready,
    output cht_pkg::t_in          o_item,
    output logic [BIN_W-1:0]      o_bin
);
    import cht_pkg::*;

    typedef enum logic [4:0] {
        F_IDLE = 5'b00001,
        F_HASH = 5'b00010,
        F_MUL  = 5'b00100,
        F_MOD  = 5'b01000,
        F_PUSH = 5'b10000
    } t_fstate;

    // reciprocal of the bin count scaled by 2^(KEY_W+BIN_W); its bit KEY_W is always set
    localparam int               QW         = KEY_W + 1 - BIN_W;
    localparam logic [63:0]      RECIP_FULL = (64'd1 << (KEY_W + BIN_W)) / 64'(NUM_BINS);
    localparam logic [KEY_W-1:0] RECIP_LO   = RECIP_FULL[KEY_W-1:0];
    localparam logic [BIN_W:0]   NB_EXT     = (BIN_W+1)'(NUM_BINS);

    t_fstate              r_state;
    t_in                  r_item;
    logic [KEY_W-1:0]     r_rest;
    logic [KEY_W-1:0]     r_hash;
    logic [QW-1:0]        r_quot;
    logic [BIN_W-1:0]     r_rem;
    logic [KEY_W-1:0]     n_hash;
    logic [2*KEY_W-1:0]   w_part;
    logic [2*KEY_W:0]     w_prod;
    logic [QW-1:0]        n_quot;
    logic [BIN_W:0]       w_qn;
    logic [BIN_W:0]       w_rp;
    logic [BIN_W:0]       w_rc;
    logic [BIN_W-1:0]     n_rem;

    // hash step: h*3 + low digit of the remaining key
    assign n_hash = r_hash + {r_hash[KEY_W-2:0], 1'b0} + {{(KEY_W-2){1'b0}}, r_rest[1:0]};

    // quotient estimate: hash times the reciprocal, low by at most one
    assign w_part = {{KEY_W{1'b0}}, r_hash} * {{KEY_W{1'b0}}, RECIP_LO};
    assign w_prod = {1'b0, r_hash, {KEY_W{1'b0}}} + {1'b0, w_part};
    assign n_quot = w_prod[2*KEY_W:KEY_W+BIN_W];

    // remainder from the low bits only, then one compare-subtract
    assign w_qn  = r_quot[BIN_W:0] * NB_EXT;
    assign w_rp  = r_hash[BIN_W:0] - w_qn;
    assign w_rc  = (w_rp >= NB_EXT) ? (w_rp - NB_EXT) : w_rp;
    assign n_rem = w_rc[BIN_W-1:0];

    assign o_ready = (r_state == F_IDLE) && i_enable;
    assign o_valid = (r_state == F_PUSH);
    assign o_item  = r_item;
    assign o_bin   = r_rem;

    // sequence accept, hash, quotient, remainder and hand-off
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            case (r_state)
                F_IDLE: begin
                    if (i_valid && o_ready) begin
                        r_item  <= i_item;
                        r_rest  <= i_item.key;
                        r_hash  <= '0;
                        r_state <= F_HASH;
                    end
                end
                F_HASH: begin
                    if (r_rest == '0) begin
                        r_state <= F_MUL;
                    end else begin
                        r_hash <= n_hash;
                        r_rest <= r_rest >> 2;
                    end
                end
                F_MUL: begin
                    r_quot  <= n_quot;
                    r_state <= F_MOD;
                end
                F_MOD: begin
                    r_rem   <= n_rem;
                    r_state <= F_PUSH;
                end
                F_PUSH: begin
                    if (i_ready) begin
                        r_state <= F_IDLE;
                    end
                end
                default: begin
                    r_state <= F_IDLE;
                end
            endcase
        end
    end

endmodule
`default_nettype wire

[rtl/cht_queue.sv]
`default_nettype none
module cht_queue #(
    parameter int BIN_W = 6
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    output logic                  o_ready,
    input  wire cht_pkg::t_in     i_item,
    input  wire logic [BIN_W-1:0] i_bin,
    output logic                  o_valid,
    input  wire logic             i_ready,
    output cht_pkg::t_in          o_item,
    output logic [BIN_W-1:0]      o_bin
);
    import cht_pkg::*;

    localparam int DEPTH = 2;
    localparam int PW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);

    t_in              r_item [DEPTH];
    logic [BIN_W-1:0] r_bin  [DEPTH];
    logic [PW-1:0]    r_wp;
    logic [PW-1:0]    r_rp;
    logic [CW-1:0]    r_cnt;
    logic             w_push;
    logic             w_pop;

    assign o_ready = (r_cnt != CW'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_item  = r_item[r_rp];
    assign o_bin   = r_bin[r_rp];
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;

    // store a pushed item
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_item[r_wp] <= i_item;
            r_bin[r_wp]  <= i_bin;
        end
    end

    // advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wp <= r_wp + PW'(1);
            end
            if (w_pop) begin
                r_rp <= r_rp + PW'(1);
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

endmodule
`default_nettype wire

[rtl/cht_back.sv]
`default_nettype none
`include "chained_hash_table_core_defines.svh"
module cht_back #(
    parameter int NUM_BINS    = cht_pkg::NUM_BINS_DEF,
    parameter int MAX_ENTRIES = cht_pkg::MAX_ENTRIES_DEF,
    parameter int BIN_W       = $clog2(NUM_BINS)
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    output logic                  o_init_done,
    input  wire logic             i_valid,
    output logic                  o_ready,
    input  wire cht_pkg::t_in     i_item,
    input  wire logic [BIN_W-1:0] i_bin,
    output logic                  o_out_valid,
    input  wire logic             i_out_ready,
    output cht_pkg::t_out         o_out_item
);
    import cht_pkg::*;

    localparam int IDX_W = $clog2(MAX_ENTRIES + 1);
    localparam int AW    = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam logic [IDX_W-1:0] NULL_IDX = IDX_W'(MAX_ENTRIES);

    typedef enum logic [3:0] {
        S_CLEAR = 4'b0001,
        S_IDLE  = 4'b0010,
        S_HEAD  = 4'b0100,
        S_WALK  = 4'b1000
    } t_bstate;

    t_bstate          r_state;
    logic [BIN_W-1:0] r_clr;
    t_in              r_item;
    logic [BIN_W-1:0] r_bin;
    logic [IDX_W-1:0] r_count;
    logic [AW-1:0]    r_cur;
    logic             r_out_valid;
    t_out             r_out;

    // bin head memory
    logic [IDX_W-1:0] bin_mem [NUM_BINS];
    logic [IDX_W-1:0] r_head_q;
    logic             bin_we;
    logic [BIN_W-1:0] bin_waddr;
    logic [IDX_W-1:0] bin_wdata;

    // entry memory: key, data, link and removed flag share one address
    logic [KEY_W-1:0]  ent_key  [MAX_ENTRIES];
    logic [DATA_W-1:0] ent_val  [MAX_ENTRIES];
    logic [IDX_W-1:0]  ent_link [MAX_ENTRIES];
    logic              ent_dead [MAX_ENTRIES];
    logic [KEY_W-1:0]  r_key_q;
    logic [DATA_W-1:0] r_val_q;
    logic [IDX_W-1:0]  r_link_q;
    logic              r_dead_q;
    logic              ent_re;
    logic [AW-1:0]     ent_raddr;
    logic              ent_we;
    logic [AW-1:0]     ent_waddr;
    logic [KEY_W-1:0]  ent_wkey;
    logic [DATA_W-1:0] ent_wval;
    logic [IDX_W-1:0]  ent_wlink;
    logic              ent_wdead;

    logic    w_out_free;
    logic    w_pop;
    logic    w_full;
    logic    w_head_ok;
    logic    w_link_ok;
    logic    w_match;
    logic    w_ins_ok;
    logic    set_out;
    t_out    n_out;
    t_bstate n_state;

    assign w_out_free  = !r_out_valid || i_out_ready;
    assign o_ready     = (r_state == S_IDLE) && w_out_free;
    assign w_pop       = o_ready && i_valid;
    assign o_init_done = (r_state != S_CLEAR);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    assign w_full    = (r_count == NULL_IDX);
    assign w_head_ok = (r_head_q < NULL_IDX);
    assign w_link_ok = (r_link_q < NULL_IDX);
    assign w_match   = !r_dead_q && (r_key_q == r_item.key);
    assign w_ins_ok  = (r_state == S_HEAD) && (r_item.command == CMD_INSERT) && !w_full;

    // decode the current step into memory ports, result and next state
    always_comb begin
        bin_we    = 1'b0;
        bin_waddr = r_bin;
        bin_wdata = r_count;
        ent_re    = 1'b0;
        ent_raddr = r_head_q[AW-1:0];
        ent_we    = 1'b0;
        ent_waddr = r_count[AW-1:0];
        ent_wkey  = r_item.key;
        ent_wval  = r_item.data_in;
        ent_wlink = r_head_q;
        ent_wdead = 1'b0;
        set_out   = 1'b0;
        n_out     = '{status: STAT_MISS, data_out: '0};
        n_state   = r_state;
        case (r_state)
            S_CLEAR: begin
                bin_we    = 1'b1;
                bin_waddr = r_clr;
                bin_wdata = NULL_IDX;
                if (r_clr == BIN_W'(NUM_BINS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_pop) begin
                    n_state = S_HEAD;
                end
            end
            S_HEAD: begin
                case (r_item.command)
                    CMD_INSERT: begin
                        set_out = 1'b1;
                        if (w_full) begin
                            n_out.status = STAT_FULL;
                        end else begin
                            n_out.status = STAT_OK;
                            bin_we       = 1'b1;
                            ent_we       = 1'b1;
                        end
                    end
                    CMD_LOOKUP, CMD_REMOVE: begin
                        if (w_head_ok) begin
                            ent_re  = 1'b1;
                            n_state = S_WALK;
                        end else begin
                            set_out = 1'b1;
                        end
                    end
                    default: begin
                        set_out = 1'b1;
                    end
                endcase
            end
            S_WALK: begin
                if (w_match) begin
                    set_out        = 1'b1;
                    n_out.status   = STAT_OK;
                    n_out.data_out = r_val_q;
                    if (r_item.command == CMD_REMOVE) begin
                        ent_we    = 1'b1;
                        ent_waddr = r_cur;
                        ent_wkey  = r_key_q;
                        ent_wval  = r_val_q;
                        ent_wlink = r_link_q;
                        ent_wdead = 1'b1;
                    end
                end else if (w_link_ok) begin
                    ent_re    = 1'b1;
                    ent_raddr = r_link_q[AW-1:0];
                end else begin
                    set_out = 1'b1;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
        if (set_out) begin
            n_state = S_IDLE;
        end
    end

    // bin head memory: one write, one registered read
    always_ff @(posedge i_clk) begin
        if (bin_we) begin
            bin_mem[bin_waddr] <= bin_wdata;
        end
        if (w_pop) begin
            r_head_q <= bin_mem[i_bin];
        end
    end

    // entry memory: one write, one registered read
    always_ff @(posedge i_clk) begin
        if (ent_we) begin
            ent_key[ent_waddr]  <= ent_wkey;
            ent_val[ent_waddr]  <= ent_wval;
            ent_link[ent_waddr] <= ent_wlink;
            ent_dead[ent_waddr] <= ent_wdead;
        end
        if (ent_re) begin
            r_key_q  <= ent_key[ent_raddr];
            r_val_q  <= ent_val[ent_raddr];
            r_link_q <= ent_link[ent_raddr];
            r_dead_q <= ent_dead[ent_raddr];
        end
    end

    // hold the current item, walk position and result
    always_ff @(posedge i_clk) begin
        if (w_pop) begin
            r_item <= i_item;
            r_bin  <= i_bin;
        end
        if (ent_re) begin
            r_cur <= ent_raddr;
        end
        if (set_out) begin
            r_out <= n_out;
        end
    end

    // control: state, clear sweep, fill count, result slot
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr <= r_clr + BIN_W'(1);
            end
            if (w_ins_ok) begin
                r_count <= r_count + IDX_W'(1);
            end
            if (set_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    `CHT_ASSERT_IMPL(a_out_slot_free, set_out, w_out_free)
    `CHT_ASSERT_NEXT(a_insert_count, w_ins_ok, r_count == $past(r_count) + IDX_W'(1))
    `CHT_ASSERT_IMPL(a_clear_quiet, r_state == S_CLEAR, !r_out_valid && !o_ready)
    `CHT_ASSERT_IMPL(a_walk_written, r_state == S_WALK, r_cur < r_count)

endmodule
`default_nettype wire

[rtl/chained_hash_table_core.sv]
// Flow: the front end hashes the key one base-4 digit at a time (a key has 0 to 16 such
//   digits), then forms the quotient and remainder; the back end reads the bin head and walks the chain.
// Overlap: the front end takes a new key only after handing the last one to the two-entry
//   queue, which lets walks in the back end overlap the next hash.
// Reset: synchronous, active low; afterwards a pass over all NUM_BINS bins clears the bin heads
//   and o_in_ready stays low until it ends.
`default_nettype none
module chained_hash_table_core #(
    parameter int NUM_BINS    = cht_pkg::NUM_BINS_DEF,
    parameter int MAX_ENTRIES = cht_pkg::MAX_ENTRIES_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  wire cht_pkg::t_in  i_in_item,
    output logic               o_out_valid,
    input  wire logic          i_out_ready,
    output cht_pkg::t_out      o_out_item
);
    import cht_pkg::*;

    localparam int BIN_W = $clog2(NUM_BINS);

    logic             init_done;
    logic             fq_valid;
    logic             fq_ready;
    t_in              fq_item;
    logic [BIN_W-1:0] fq_bin;
    logic             qb_valid;
    logic             qb_ready;
    t_in              qb_item;
    logic [BIN_W-1:0] qb_bin;

    // hash front end
    cht_front #(
        .NUM_BINS (NUM_BINS),
        .BIN_W    (BIN_W)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_enable (init_done),
        .i_valid  (i_in_valid),
        .o_ready  (o_in_ready),
        .i_item   (i_in_item),
        .o_valid  (fq_valid),
        .i_ready  (fq_ready),
        .o_item   (fq_item),
        .o_bin    (fq_bin)
    );

    // decouple hashing from table access
    cht_queue #(
        .BIN_W (BIN_W)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (fq_valid),
        .o_ready (fq_ready),
        .i_item  (fq_item),
        .i_bin   (fq_bin),
        .o_valid (qb_valid),
        .i_ready (qb_ready),
        .o_item  (qb_item),
        .o_bin   (qb_bin)
    );

    // table access back end
    cht_back #(
        .NUM_BINS    (NUM_BINS),
        .MAX_ENTRIES (MAX_ENTRIES),
        .BIN_W       (BIN_W)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .o_init_done (init_done),
        .i_valid     (qb_valid),
        .o_ready     (qb_ready),
        .i_item      (qb_item),
        .i_bin       (qb_bin),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

endmodule
`default_nettype wire
